>>> rtl/flac_subframe_predictor_unit_assert.svh
// Assertion macros shared by the predictor RTL.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef FLAC_SUBFRAME_PREDICTOR_UNIT_ASSERT_SVH
`define FLAC_SUBFRAME_PREDICTOR_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define FLSP_ASSERT_HOLD(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("flsp assertion failed");

// A condition that must hold in the cycle after a trigger.
`define FLSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("flsp assertion failed");

`endif

>>> rtl/flsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flsp_pkg;

    // Sizes of the history and coefficient stores.
    localparam int unsigned MAX_ORDER  = 32;
    localparam int unsigned COEF_BITS  = 16;
    localparam int unsigned HIST_AW    = $clog2(MAX_ORDER);
    localparam int unsigned HIST_DEPTH = 2 ** HIST_AW;
    localparam int unsigned K_W        = HIST_AW + 1;
    localparam int unsigned FIXED_MAX  = 4;

    // Field widths of the items and registers.
    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned CIDX_W     = 5;
    localparam int unsigned COEF_W     = 16;
    localparam int unsigned SAMPLE_W   = 32;
    localparam int unsigned ORD_W      = 6;
    localparam int unsigned SHIFT_W    = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 6;
    localparam int unsigned PROD_W     = SAMPLE_W + COEF_W;
    localparam int unsigned ACC_W      = 64;

    // Predictor modes.
    localparam logic MODE_FIXED = 1'b0;
    localparam logic MODE_LPC   = 1'b1;

    // Input item actions.
    typedef enum logic [ACTION_W-1:0] {
        ACT_COEF  = 2'd0,
        ACT_WARM  = 2'd1,
        ACT_RESID = 2'd2
    } t_action;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_ORDER = 2'd1,
        CFG_SHIFT = 2'd2
    } t_cfg_reg;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FINISH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               mode;
        logic [ORD_W-1:0]   order;
        logic [SHIFT_W-1:0] shift;
    } t_cfg;

    // Tap control, aligned with the read data of both memories.
    typedef struct packed {
        logic                     clear;
        logic                     tap_v;
        logic                     hist_ok;
        logic                     use_fixed;
        logic signed [COEF_W-1:0] fcoef;
    } t_mac_ctl;

    typedef struct packed {
        logic                    busy;
        logic signed [ACC_W-1:0] acc;
    } t_mac_sts;

    // Binomial coefficients of the fixed predictors, tap k of order ord.
    function automatic logic signed [COEF_W-1:0] fixed_coef(input logic [2:0] ord,
                                                          input logic [1:0] k);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case ({ord, k})
            5'b001_00: c = COEF_W'(1);
            5'b010_00: c = COEF_W'(2);
            5'b010_01: c = COEF_W'(-1);
            5'b011_00: c = COEF_W'(3);
            5'b011_01: c = COEF_W'(-3);
            5'b011_10: c = COEF_W'(1);
            5'b100_00: c = COEF_W'(4);
            5'b100_01: c = COEF_W'(-6);
            5'b100_10: c = COEF_W'(4);
            5'b100_11: c = COEF_W'(-1);
            default:   c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/flsp_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Input item channel.
interface flsp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [flsp_pkg::ACTION_W-1:0]        action;
    logic [flsp_pkg::CIDX_W-1:0]          coef_index;
    logic signed [flsp_pkg::COEF_W-1:0]   coef_value;
    logic signed [flsp_pkg::SAMPLE_W-1:0] sample_value;
    logic                                 last_in;

    modport source (output valid, action, coef_index, coef_value, sample_value, last_in,
                    input ready);
    modport sink (input valid, action, coef_index, coef_value, sample_value, last_in,
                  output ready);
endinterface

// Result item channel.
interface flsp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [flsp_pkg::SAMPLE_W-1:0] sample;
    logic                                 last_out;

    modport source (output valid, sample, last_out, input ready);
    modport sink (input valid, sample, last_out, output ready);
endinterface

// Configuration write channel.
interface flsp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [flsp_pkg::CFG_IDX_W-1:0]  index;
    logic [flsp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/flsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port memory: one write port, one read port, registered read.
module flsp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/flsp_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Multiply-accumulate pipeline: one history tap times one coefficient per cycle.
module flsp_mac (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  flsp_pkg::t_mac_ctl               i_ctl,
    input  logic [flsp_pkg::SAMPLE_W-1:0]    i_hist_data,
    input  logic [flsp_pkg::COEF_W-1:0]      i_coef_data,
    output flsp_pkg::t_mac_sts               o_sts
);

    logic signed [flsp_pkg::SAMPLE_W-1:0] hist_op;
    logic signed [flsp_pkg::COEF_W-1:0]   coef_op;
    logic signed [flsp_pkg::PROD_W-1:0]   r_prod;
    logic                                 r_prod_v;
    logic signed [flsp_pkg::ACC_W-1:0]    r_acc;

    // History slots never written since reset read as zero.
    assign hist_op = i_ctl.hist_ok ? i_hist_data : '0;
    assign coef_op = i_ctl.use_fixed ? i_ctl.fcoef : i_coef_data;

    // Product stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.tap_v;
        end
    end

    // Product register and 64-bit accumulator.
    always_ff @(posedge i_clk) begin
        if (i_ctl.tap_v) begin
            r_prod <= hist_op * coef_op;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + flsp_pkg::ACC_W'(r_prod);
        end
    end

    assign o_sts.busy = r_prod_v;
    assign o_sts.acc  = r_acc;

endmodule

`default_nettype wire

>>> rtl/flsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "flac_subframe_predictor_unit_assert.svh"

// Item sequencer: memory addressing, tap issue, result write-back and output register.
module flsp_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    flsp_in_if.sink                             i_in,
    flsp_out_if.source                          o_out,
    input  flsp_pkg::t_cfg                      i_cfg,
    output logic                                o_hist_we,
    output logic [flsp_pkg::HIST_AW-1:0]        o_hist_waddr,
    output logic [flsp_pkg::SAMPLE_W-1:0]       o_hist_wdata,
    output logic [flsp_pkg::HIST_AW-1:0]        o_hist_raddr,
    output logic                                o_coef_we,
    output logic [flsp_pkg::HIST_AW-1:0]        o_coef_waddr,
    output logic [flsp_pkg::COEF_W-1:0]         o_coef_wdata,
    output logic [flsp_pkg::HIST_AW-1:0]        o_coef_raddr,
    output flsp_pkg::t_mac_ctl                  o_mac_ctl,
    input  flsp_pkg::t_mac_sts                  i_mac_sts
);

    flsp_pkg::t_state                        r_state;
    flsp_pkg::t_state                        n_state;
    logic [flsp_pkg::HIST_AW-1:0]            r_head;
    logic [flsp_pkg::HIST_DEPTH-1:0]         r_hvalid;
    logic [flsp_pkg::K_W-1:0]                r_k;
    logic [flsp_pkg::K_W-1:0]                r_ord;
    logic                                    r_fixed;
    logic                                    r_tap_v;
    logic                                    r_tap_hv;
    logic signed [flsp_pkg::COEF_W-1:0]      r_tap_fc;
    logic signed [flsp_pkg::SAMPLE_W-1:0]    r_sv;
    logic                                    r_last;
    logic [flsp_pkg::SAMPLE_W-1:0]           r_result;
    logic                                    r_out_valid;
    logic [flsp_pkg::SAMPLE_W-1:0]           r_out_sample;
    logic                                    r_out_last;

    logic                                    accept;
    logic                                    out_free;
    logic                                    issue;
    logic                                    load_out;
    logic [flsp_pkg::HIST_AW-1:0]            hist_raddr;
    logic [flsp_pkg::HIST_AW-1:0]            wr_addr;
    logic [flsp_pkg::K_W-1:0]                ord_clamped;
    logic signed [flsp_pkg::ACC_W-1:0]       acc_shifted;
    logic [flsp_pkg::SAMPLE_W-1:0]           fin_result;

    // Handshake and tap issue.
    assign i_in.ready = (r_state == flsp_pkg::ST_IDLE);
    assign accept     = i_in.valid && (r_state == flsp_pkg::ST_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign issue      = (r_state == flsp_pkg::ST_MAC) && (r_k < r_ord);

    // Circular history: newest sample at r_head, tap k at r_head - k.
    assign hist_raddr = r_head - r_k[flsp_pkg::HIST_AW-1:0];
    assign wr_addr    = r_head + flsp_pkg::HIST_AW'(1);

    // Order clamp per mode.
    always_comb begin
        if (i_cfg.mode == flsp_pkg::MODE_FIXED) begin
            ord_clamped = (i_cfg.order > flsp_pkg::ORD_W'(flsp_pkg::FIXED_MAX))
                        ? flsp_pkg::K_W'(flsp_pkg::FIXED_MAX)
                        : flsp_pkg::K_W'(i_cfg.order);
        end else begin
            ord_clamped = (i_cfg.order > flsp_pkg::ORD_W'(flsp_pkg::MAX_ORDER))
                        ? flsp_pkg::K_W'(flsp_pkg::MAX_ORDER)
                        : flsp_pkg::K_W'(i_cfg.order);
        end
    end

    // Final prediction: the LPC sum is shifted, the fixed sum is used as is;
    // the residual is added, wrapping at the sample width.
    assign acc_shifted = r_fixed ? i_mac_sts.acc : (i_mac_sts.acc >>> i_cfg.shift);
    assign fin_result  = acc_shifted[flsp_pkg::SAMPLE_W-1:0] + r_sv;

    // Next state.
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        case (r_state)
            flsp_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_in.action)
                        flsp_pkg::ACT_WARM:  n_state = flsp_pkg::ST_DONE;
                        flsp_pkg::ACT_RESID: n_state = flsp_pkg::ST_MAC;
                        default:             n_state = flsp_pkg::ST_IDLE;
                    endcase
                end
            end
            flsp_pkg::ST_MAC: begin
                if (!issue && !r_tap_v && !i_mac_sts.busy) begin
                    n_state = flsp_pkg::ST_FINISH;
                end
            end
            flsp_pkg::ST_FINISH: begin
                n_state = flsp_pkg::ST_DONE;
            end
            flsp_pkg::ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = flsp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = flsp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= flsp_pkg::ST_IDLE;
            r_head      <= '0;
            r_hvalid    <= '0;
            r_k         <= '0;
            r_ord       <= '0;
            r_tap_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tap_v <= issue;
            if (load_out) begin
                r_head           <= wr_addr;
                r_hvalid[wr_addr] <= 1'b1;
            end
            if (accept) begin
                r_k   <= '0;
                r_ord <= ord_clamped;
            end else if (issue) begin
                r_k <= r_k + flsp_pkg::K_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sv    <= i_in.sample_value;
            r_last  <= i_in.last_in;
            r_fixed <= (i_cfg.mode == flsp_pkg::MODE_FIXED);
        end
        if (accept && (i_in.action == flsp_pkg::ACT_WARM)) begin
            r_result <= i_in.sample_value;
        end else if (r_state == flsp_pkg::ST_FINISH) begin
            r_result <= fin_result;
        end
        r_tap_hv <= r_hvalid[hist_raddr];
        r_tap_fc <= flsp_pkg::fixed_coef(r_ord[2:0], r_k[1:0]);
        if (load_out) begin
            r_out_sample <= r_result;
            r_out_last   <= r_last;
        end
    end

    // Memory ports.
    assign o_hist_we    = load_out;
    assign o_hist_waddr = wr_addr;
    assign o_hist_wdata = r_result;
    assign o_hist_raddr = hist_raddr;
    assign o_coef_we    = accept && (i_in.action == flsp_pkg::ACT_COEF)
                        && (32'(i_in.coef_index) < flsp_pkg::MAX_ORDER);
    assign o_coef_waddr = i_in.coef_index[flsp_pkg::HIST_AW-1:0];
    assign o_coef_wdata = flsp_pkg::COEF_W'($signed(i_in.coef_value[flsp_pkg::COEF_BITS-1:0]));
    assign o_coef_raddr = r_k[flsp_pkg::HIST_AW-1:0];

    // Tap control toward the multiply-accumulate pipeline.
    always_comb begin
        o_mac_ctl.clear     = accept && (i_in.action == flsp_pkg::ACT_RESID);
        o_mac_ctl.tap_v     = r_tap_v;
        o_mac_ctl.hist_ok   = r_tap_hv;
        o_mac_ctl.use_fixed = r_fixed;
        o_mac_ctl.fcoef     = r_tap_fc;
    end

    // Output register.
    assign o_out.valid    = r_out_valid;
    assign o_out.sample   = r_out_sample;
    assign o_out.last_out = r_out_last;

    // Checks on the sequencing.
    `FLSP_ASSERT_HOLD(a_k_bound, r_k <= r_ord)
    `FLSP_ASSERT_HOLD(a_tap_in_mac, !r_tap_v || (r_state == flsp_pkg::ST_MAC))
    `FLSP_ASSERT_HOLD(a_finish_drained, (r_state != flsp_pkg::ST_FINISH) || !i_mac_sts.busy)
    `FLSP_ASSERT_HOLD(a_no_read_on_write, !(o_hist_we && issue))
    `FLSP_ASSERT_NEXT(a_write_shows, o_hist_we, o_out.valid)

endmodule

`default_nettype wire

>>> rtl/flac_subframe_predictor_unit.sv
// Channel   Direction  Payload
// i_in      sink       action, coef_index, coef_value, sample_value, last_in
// o_out     source     sample, last_out
// i_cfg     sink       index, data (0 mode, 1 order, 2 quant shift)
//
// Coefficient and warm-up items issue no taps. A residual item issues one tap per cycle,
// up to its order (clamped to 4 in fixed mode and to 32 in LPC mode), through each
// memory's single read port. Reset clears the control state, the configuration and the
// history valid bits; there is no clearing pass. The result sits in an output register,
// so the next item is accepted while it waits; an item finishing while that register
// is full holds.
`timescale 1ns / 1ps
`default_nettype none

module flac_subframe_predictor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    flsp_in_if.sink     i_in,
    flsp_out_if.source  o_out,
    flsp_cfg_if.sink    i_cfg
);

    flsp_pkg::t_cfg                   r_cfg;
    logic                             hist_we;
    logic [flsp_pkg::HIST_AW-1:0]     hist_waddr;
    logic [flsp_pkg::SAMPLE_W-1:0]    hist_wdata;
    logic [flsp_pkg::HIST_AW-1:0]     hist_raddr;
    logic [flsp_pkg::SAMPLE_W-1:0]    hist_rdata;
    logic                             coef_we;
    logic [flsp_pkg::HIST_AW-1:0]     coef_waddr;
    logic [flsp_pkg::COEF_W-1:0]      coef_wdata;
    logic [flsp_pkg::HIST_AW-1:0]     coef_raddr;
    logic [flsp_pkg::COEF_W-1:0]      coef_rdata;
    flsp_pkg::t_mac_ctl               mac_ctl;
    flsp_pkg::t_mac_sts               mac_sts;

    // Configuration registers; writes beyond the list are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                flsp_pkg::CFG_MODE:  r_cfg.mode  <= i_cfg.data[0];
                flsp_pkg::CFG_ORDER: r_cfg.order <= i_cfg.data[flsp_pkg::ORD_W-1:0];
                flsp_pkg::CFG_SHIFT: r_cfg.shift <= i_cfg.data[flsp_pkg::SHIFT_W-1:0];
                default:             r_cfg       <= r_cfg;
            endcase
        end
    end

    // History memory, used as a circular buffer.
    flsp_ram #(
        .WIDTH (flsp_pkg::SAMPLE_W),
        .DEPTH (flsp_pkg::HIST_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    // Coefficient memory.
    flsp_ram #(
        .WIDTH (flsp_pkg::COEF_W),
        .DEPTH (flsp_pkg::MAX_ORDER)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    // Sequencer.
    flsp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .i_cfg        (r_cfg),
        .o_hist_we    (hist_we),
        .o_hist_waddr (hist_waddr),
        .o_hist_wdata (hist_wdata),
        .o_hist_raddr (hist_raddr),
        .o_coef_we    (coef_we),
        .o_coef_waddr (coef_waddr),
        .o_coef_wdata (coef_wdata),
        .o_coef_raddr (coef_raddr),
        .o_mac_ctl    (mac_ctl),
        .i_mac_sts    (mac_sts)
    );

    // Multiply-accumulate pipeline.
    flsp_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_hist_data (hist_rdata),
        .i_coef_data (coef_rdata),
        .o_sts       (mac_sts)
    );

endmodule

`default_nettype wire

>>> test/flac_subframe_predictor_unit_tb.sv
`timescale 1ns / 1ps

module flac_subframe_predictor_unit_tb;

    // The action code that the block must ignore.
    localparam logic [flsp_pkg::ACTION_W-1:0] ACT_RESERVED = 2'd3;

    localparam int N_PHASES     = 14;
    localparam int PHASE_ITEMS  = 38;
    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [flsp_pkg::ACTION_W-1:0]        action;
        logic [flsp_pkg::CIDX_W-1:0]          idx;
        logic signed [flsp_pkg::COEF_W-1:0]   coef;
        logic signed [flsp_pkg::SAMPLE_W-1:0] sval;
        logic                                 last;
    } t_in_item;

    typedef struct packed {
        logic signed [flsp_pkg::SAMPLE_W-1:0] sample;
        logic                                 last;
    } t_rebuilt;

    typedef struct packed {
        logic                         mode;
        logic [flsp_pkg::ORD_W-1:0]   order;
        logic [flsp_pkg::SHIFT_W-1:0] shift;
    } t_setting;

    logic i_clk = 1'b0;
    logic i_rst_n;

    flsp_in_if  in_ch ();
    flsp_out_if out_ch ();
    flsp_cfg_if cfg_ch ();

    flac_subframe_predictor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow of the block: configuration, history (newest first) and coefficients.
    logic                                 cfg_mode  = flsp_pkg::MODE_FIXED;
    logic [flsp_pkg::ORD_W-1:0]           cfg_order = '0;
    logic [flsp_pkg::SHIFT_W-1:0]         cfg_shift = '0;
    logic signed [flsp_pkg::SAMPLE_W-1:0] hist     [flsp_pkg::MAX_ORDER];
    logic signed [flsp_pkg::COEF_W-1:0]   coef_tbl [flsp_pkg::MAX_ORDER];
    logic [flsp_pkg::MAX_ORDER-1:0]       coef_loaded = '0;

    t_in_item pending [$];
    t_rebuilt rebuilt_q [$];
    t_in_item nxt;

    int  sample_items    = 0;
    int  coef_items      = 0;
    int  ignored_items   = 0;
    int  samples_checked = 0;
    int  mismatches      = 0;
    int  tx_idle_left    = 0;
    int  rx_idle_left    = 0;
    int  hold_left       = 0;
    bit  hold_done       = 1'b0;
    bit  idle_en         = 1'b1;
    logic in_taken       = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Number of history taps that the current configuration uses.
    function automatic int eff_order();
        if (cfg_mode == flsp_pkg::MODE_FIXED) begin
            return (cfg_order > flsp_pkg::FIXED_MAX) ? int'(flsp_pkg::FIXED_MAX)
                                                     : int'(cfg_order);
        end
        return (cfg_order > flsp_pkg::MAX_ORDER) ? int'(flsp_pkg::MAX_ORDER) : int'(cfg_order);
    endfunction

    // Prediction from the history, before the residual is added.
    function automatic longint predicted_value();
        longint h0, h1, h2, h3, sum;
        int     taps;
        h0   = hist[0];
        h1   = hist[1];
        h2   = hist[2];
        h3   = hist[3];
        taps = eff_order();
        sum  = 0;
        if (cfg_mode == flsp_pkg::MODE_FIXED) begin
            case (taps)
                0:       sum = 0;
                1:       sum = h0;
                2:       sum = 2 * h0 - h1;
                3:       sum = 3 * h0 - 3 * h1 + h2;
                default: sum = 4 * h0 - 6 * h1 + 4 * h2 - h3;
            endcase
        end else begin
            for (int k = 0; k < taps; k++) begin
                sum += longint'(coef_tbl[k]) * longint'(hist[k]);
            end
            sum = sum >>> cfg_shift;
        end
        return sum;
    endfunction

    // Update the shadow for one accepted item and queue the sample it yields.
    task automatic take_item(t_in_item it);
        t_rebuilt r;
        case (it.action)
            flsp_pkg::ACT_COEF: begin
                coef_tbl[it.idx] = it.coef;
                return;
            end
            flsp_pkg::ACT_WARM:  r.sample = it.sval;
            flsp_pkg::ACT_RESID: r.sample = flsp_pkg::SAMPLE_W'(predicted_value()
                                                                + longint'(it.sval));
            default:             return;
        endcase
        r.last = it.last;
        for (int k = flsp_pkg::MAX_ORDER - 1; k > 0; k--) begin
            hist[k] = hist[k-1];
        end
        hist[0] = r.sample;
        rebuilt_q.push_back(r);
    endtask

    function automatic void flag(string msg);
        if (mismatches < 10) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endfunction

    task automatic check_result(logic signed [flsp_pkg::SAMPLE_W-1:0] got, logic got_last);
        t_rebuilt want;
        samples_checked++;
        if (rebuilt_q.size() == 0) begin
            flag($sformatf("sample %0d arrived with nothing expected (value %0d)",
                           samples_checked, got));
            return;
        end
        want = rebuilt_q.pop_front();
        if (got !== want.sample) begin
            flag($sformatf("sample %0d: expected %0d, got %0d",
                           samples_checked, want.sample, got));
        end
        if (got_last !== want.last) begin
            flag($sformatf("sample %0d last flag: expected %0b, got %0b",
                           samples_checked, want.last, got_last));
        end
    endtask

    // Monitor: input acceptances feed the predictor, output acceptances are checked.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                take_item(t_in_item'{in_ch.action, in_ch.coef_index, in_ch.coef_value,
                                     in_ch.sample_value, in_ch.last_in});
            end
            if (out_ch.valid && out_ch.ready) begin
                check_result(out_ch.sample, out_ch.last_out);
            end
        end
    end

    // Driver: presents queued items, with random idle bursts between them.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (tx_idle_left > 0) begin
                tx_idle_left <= tx_idle_left - 1;
                in_ch.valid  <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                tx_idle_left <= $urandom_range(0, 10);
                in_ch.valid  <= 1'b0;
            end else if (pending.size() > 0) begin
                nxt = pending.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.action       <= nxt.action;
                in_ch.coef_index   <= nxt.idx;
                in_ch.coef_value   <= nxt.coef;
                in_ch.sample_value <= nxt.sval;
                in_ch.last_in      <= nxt.last;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // One long output hold-off while input items are still waiting.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && samples_checked >= 100 && pending.size() > 10) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver: ready with random stall bursts, and low during the hold-off.
    always @(negedge i_clk) begin
        if (rx_idle_left > 0) begin
            rx_idle_left <= rx_idle_left - 1;
            out_ch.ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            rx_idle_left <= $urandom_range(0, 10);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= (hold_left == 0);
        end
    end

    task automatic add_item(logic [flsp_pkg::ACTION_W-1:0] act,
                            logic [flsp_pkg::CIDX_W-1:0] idx,
                            logic [flsp_pkg::COEF_W-1:0] cv,
                            logic [flsp_pkg::SAMPLE_W-1:0] sv, logic lst);
        pending.push_back(t_in_item'{act, idx, cv, sv, lst});
        case (act)
            flsp_pkg::ACT_COEF: begin
                coef_loaded[idx] = 1'b1;
                coef_items++;
            end
            flsp_pkg::ACT_WARM, flsp_pkg::ACT_RESID: sample_items++;
            default:                                 ignored_items++;
        endcase
    endtask

    // Sample values: full range, small, medium, and the two extremes.
    function automatic logic [flsp_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return flsp_pkg::SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            2:       return flsp_pkg::SAMPLE_W'(int'($urandom_range(0, 65535)) - 32768);
            default: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // LPC residuals must never read a coefficient slot that was never loaded.
    task automatic load_missing_coefs();
        for (int k = 0; k < eff_order(); k++) begin
            if (!coef_loaded[k]) begin
                add_item(flsp_pkg::ACT_COEF, flsp_pkg::CIDX_W'(k),
                         flsp_pkg::COEF_W'($urandom), $urandom,
                         1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Mostly whole subframes with random content, the rest broken ones and noise.
    task automatic fill_random_phase(int budget);
        int made, pick, n_warm, n_res;
        made = 0;
        while (made < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                n_warm = eff_order();
                n_res  = $urandom_range(1, 16);
                if (cfg_mode == flsp_pkg::MODE_LPC) begin
                    for (int k = 0; k < n_warm; k++) begin
                        if ($urandom_range(0, 3) == 0) begin
                            add_item(flsp_pkg::ACT_COEF, flsp_pkg::CIDX_W'(k),
                                     flsp_pkg::COEF_W'($urandom), $urandom,
                                     1'($urandom_range(0, 1)));
                        end
                    end
                end
                for (int k = 0; k < n_warm; k++) begin
                    add_item(flsp_pkg::ACT_WARM, flsp_pkg::CIDX_W'($urandom),
                             flsp_pkg::COEF_W'($urandom), rand_sample(), 1'b0);
                end
                for (int k = 0; k < n_res; k++) begin
                    add_item(flsp_pkg::ACT_RESID, flsp_pkg::CIDX_W'($urandom),
                             flsp_pkg::COEF_W'($urandom), rand_sample(), k == n_res - 1);
                end
                made += n_warm + n_res;
            end else if (pick < 84) begin
                // Short or missing warm-up, stray end marks.
                n_res = $urandom_range(1, 6);
                for (int k = 0; k < n_res; k++) begin
                    add_item(($urandom_range(0, 1) != 0) ? flsp_pkg::ACT_WARM
                                                         : flsp_pkg::ACT_RESID,
                             flsp_pkg::CIDX_W'($urandom), flsp_pkg::COEF_W'($urandom),
                             rand_sample(), 1'($urandom_range(0, 1)));
                end
                made += n_res;
            end else if (pick < 94) begin
                add_item(flsp_pkg::ACT_COEF, flsp_pkg::CIDX_W'($urandom),
                         flsp_pkg::COEF_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end else begin
                add_item(ACT_RESERVED, flsp_pkg::CIDX_W'($urandom),
                         flsp_pkg::COEF_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic set_register(flsp_pkg::t_cfg_reg idx,
                                logic [flsp_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            flsp_pkg::CFG_MODE:  cfg_mode  = val[0];
            flsp_pkg::CFG_ORDER: cfg_order = val;
            flsp_pkg::CFG_SHIFT: cfg_shift = val[flsp_pkg::SHIFT_W-1:0];
            default:             ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_setting(t_setting s);
        set_register(flsp_pkg::CFG_MODE, flsp_pkg::CFG_DATA_W'(s.mode));
        set_register(flsp_pkg::CFG_ORDER, s.order);
        set_register(flsp_pkg::CFG_SHIFT, flsp_pkg::CFG_DATA_W'(s.shift));
    endtask

    // Wait until every item is taken and every sample is back, then let the
    // block finish any coefficient write still in flight.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending.size() != 0 || in_ch.valid || rebuilt_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register settings of the random phases, extremes and clamped orders included.
    function automatic t_setting setting_for(int phase);
        case (phase)
            0:       return t_setting'{flsp_pkg::MODE_FIXED, 6'd0, 4'd0};
            1:       return t_setting'{flsp_pkg::MODE_FIXED, 6'd1, 4'd15};
            2:       return t_setting'{flsp_pkg::MODE_FIXED, 6'd2, 4'd3};
            3:       return t_setting'{flsp_pkg::MODE_FIXED, 6'd3, 4'd0};
            4:       return t_setting'{flsp_pkg::MODE_FIXED, 6'd4, 4'd9};
            5:       return t_setting'{flsp_pkg::MODE_FIXED, 6'd63, 4'd15};
            6:       return t_setting'{flsp_pkg::MODE_LPC, 6'd0, 4'd15};
            7:       return t_setting'{flsp_pkg::MODE_LPC, 6'd1, 4'd0};
            8:       return t_setting'{flsp_pkg::MODE_LPC, 6'd8, 4'd15};
            9:       return t_setting'{flsp_pkg::MODE_LPC, 6'd32, 4'd12};
            10:      return t_setting'{flsp_pkg::MODE_LPC, 6'd63, 4'd15};
            11:      return t_setting'{flsp_pkg::MODE_LPC, 6'd3, 4'd7};
            default: return t_setting'{1'($urandom_range(0, 1)),
                                       flsp_pkg::ORD_W'($urandom_range(0, 63)),
                                       flsp_pkg::SHIFT_W'($urandom)};
        endcase
    endfunction

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.action       = flsp_pkg::ACT_COEF;
        in_ch.coef_index   = '0;
        in_ch.coef_value   = '0;
        in_ch.sample_value = '0;
        in_ch.last_in      = 1'b0;
        out_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = flsp_pkg::CFG_MODE;
        cfg_ch.data        = '0;
        for (int k = 0; k < flsp_pkg::MAX_ORDER; k++) begin
            hist[k]     = '0;
            coef_tbl[k] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Order 0 with an empty history, field extremes, an ignored action,
        // and a subframe end mark on a warm-up sample.
        apply_setting(t_setting'{flsp_pkg::MODE_FIXED, 6'd0, 4'd0});
        add_item(flsp_pkg::ACT_RESID, 5'd0, 16'h0000, 32'h1234_5678, 1'b0);
        add_item(flsp_pkg::ACT_WARM, 5'd31, 16'hFFFF, 32'h7FFF_FFFF, 1'b0);
        add_item(flsp_pkg::ACT_WARM, 5'd0, 16'h0000, 32'h8000_0000, 1'b0);
        add_item(flsp_pkg::ACT_WARM, 5'd0, 16'h0000, 32'h0000_0000, 1'b0);
        add_item(flsp_pkg::ACT_WARM, 5'd0, 16'h0000, 32'hFFFF_FFFF, 1'b1);
        add_item(ACT_RESERVED, 5'd31, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        add_item(flsp_pkg::ACT_COEF, 5'd0, 16'h8000, 32'h0000_0000, 1'b0);
        add_item(flsp_pkg::ACT_COEF, 5'd31, 16'h7FFF, 32'hFFFF_FFFF, 1'b1);
        add_item(flsp_pkg::ACT_RESID, 5'd0, 16'h0000, 32'h8000_0000, 1'b1);
        wait_drained();

        // Fixed order above four clamps to four; alternating extremes wrap.
        apply_setting(t_setting'{flsp_pkg::MODE_FIXED, 6'd63, 4'd0});
        add_item(flsp_pkg::ACT_WARM, 5'd0, 16'h0000, 32'h8000_0000, 1'b0);
        add_item(flsp_pkg::ACT_WARM, 5'd0, 16'h0000, 32'h7FFF_FFFF, 1'b0);
        add_item(flsp_pkg::ACT_WARM, 5'd0, 16'h0000, 32'h8000_0000, 1'b0);
        add_item(flsp_pkg::ACT_WARM, 5'd0, 16'h0000, 32'h7FFF_FFFF, 1'b0);
        add_item(flsp_pkg::ACT_RESID, 5'd0, 16'h0000, 32'h7FFF_FFFF, 1'b0);
        add_item(flsp_pkg::ACT_RESID, 5'd0, 16'h0000, 32'h0000_0000, 1'b1);
        wait_drained();

        // LPC with a coefficient of minus one and the largest shift.
        apply_setting(t_setting'{flsp_pkg::MODE_LPC, 6'd2, 4'd15});
        add_item(flsp_pkg::ACT_COEF, 5'd1, 16'hFFFF, 32'h0000_0000, 1'b0);
        add_item(flsp_pkg::ACT_RESID, 5'd0, 16'h0000, 32'h7FFF_FFFF, 1'b0);
        add_item(flsp_pkg::ACT_RESID, 5'd0, 16'h0000, 32'h8000_0000, 1'b1);
        wait_drained();

        // Random phases, one register setting each; the last runs without idling.
        for (int p = 0; p < N_PHASES; p++) begin
            idle_en = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
            apply_setting(setting_for(p));
            if (cfg_mode == flsp_pkg::MODE_LPC) begin
                load_missing_coefs();
            end
            fill_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        $display("Covered %0d sample items and %0d coefficient loads over %0d settings;",
                 sample_items, coef_items, N_PHASES + 3);
        $display("%0d samples compared, %0d ignored items, long output hold-off %s.",
                 samples_checked, ignored_items, hold_done ? "applied" : "not reached");
        if (mismatches == 0) begin
            $display("flac_subframe_predictor_unit_tb: done, clean");
        end else begin
            $display("flac_subframe_predictor_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d items pending and %0d samples outstanding.",
                 pending.size(), rebuilt_q.size());
        $display("flac_subframe_predictor_unit_tb: done, errors");
        $finish;
    end

endmodule
